/* src/tgpr_pkg.sv */
package tgpr_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] COLUMN_OFFSET_RESET = 8'd53;
  localparam logic [7:0] ROW_OFFSET_RESET    = 8'd40;

  localparam logic [7:0] FIRST_CODE = 8'd32;
  localparam logic [7:0] LAST_CODE  = 8'd90;
  localparam logic [7:0] END_CODE   = 8'd0;
  localparam logic [9:0] ADVANCE    = 10'd6;
  localparam logic [2:0] LAST_GLYPH_COL = 3'd4;
  localparam logic [2:0] LAST_GLYPH_ROW = 3'd7;

  // Configuration register indexes.
  localparam logic REG_COLUMN_OFFSET = 1'b0;
  localparam logic REG_ROW_OFFSET    = 1'b1;

  // Element c holds the font byte shown at screen column c of the glyph.
  typedef logic [4:0][7:0] glyph_t;

  typedef struct packed {
    logic [8:0]  x;
    logic [7:0]  y;
    logic [5:0]  idx;
    logic [2:0]  last_col;
    logic [2:0]  last_row;
    logic [15:0] fg;
    logic [15:0] bg;
  } job_t;

  // Font bytes are listed in table order; packing them this way reverses the columns.
  function automatic glyph_t font_cols(input logic [5:0] idx);
    glyph_t g;
    case (idx)
      6'd0:  g = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      6'd1:  g = {8'h00, 8'h00, 8'h5F, 8'h00, 8'h00};
      6'd2:  g = {8'h00, 8'h07, 8'h00, 8'h07, 8'h00};
      6'd3:  g = {8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14};
      6'd4:  g = {8'h12, 8'h2A, 8'h7F, 8'h2A, 8'h24};
      6'd5:  g = {8'h62, 8'h64, 8'h08, 8'h13, 8'h23};
      6'd6:  g = {8'h50, 8'h22, 8'h55, 8'h49, 8'h36};
      6'd7:  g = {8'h00, 8'h00, 8'h04, 8'h03, 8'h00};
      6'd8:  g = {8'h00, 8'h41, 8'h22, 8'h1C, 8'h00};
      6'd9:  g = {8'h00, 8'h1C, 8'h22, 8'h41, 8'h00};
      6'd10: g = {8'h14, 8'h08, 8'h3E, 8'h08, 8'h14};
      6'd11: g = {8'h08, 8'h08, 8'h3E, 8'h08, 8'h08};
      6'd12: g = {8'h00, 8'h30, 8'h50, 8'h00, 8'h00};
      6'd13: g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
      6'd14: g = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
      6'd15: g = {8'h02, 8'h04, 8'h08, 8'h10, 8'h20};
      6'd16: g = {8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
      6'd17: g = {8'h00, 8'h40, 8'h7F, 8'h42, 8'h00};
      6'd18: g = {8'h46, 8'h49, 8'h51, 8'h61, 8'h42};
      6'd19: g = {8'h31, 8'h4B, 8'h45, 8'h41, 8'h21};
      6'd20: g = {8'h10, 8'h7F, 8'h12, 8'h14, 8'h18};
      6'd21: g = {8'h39, 8'h49, 8'h49, 8'h49, 8'h2F};
      6'd22: g = {8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C};
      6'd23: g = {8'h07, 8'h0D, 8'h09, 8'h71, 8'h01};
      6'd24: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      6'd25: g = {8'h1E, 8'h29, 8'h49, 8'h49, 8'h0E};
      6'd26: g = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
      6'd27: g = {8'h00, 8'h36, 8'h76, 8'h00, 8'h00};
      6'd28: g = {8'h00, 8'h41, 8'h22, 8'h14, 8'h08};
      6'd29: g = {8'h14, 8'h14, 8'h14, 8'h14, 8'h14};
      6'd30: g = {8'h08, 8'h14, 8'h22, 8'h41, 8'h00};
      6'd31: g = {8'h06, 8'h09, 8'h51, 8'h01, 8'h06};
      6'd32: g = {8'h1E, 8'h55, 8'h59, 8'h41, 8'h3E};
      6'd33: g = {8'h7E, 8'h09, 8'h09, 8'h09, 8'h7E};
      6'd34: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h7F};
      6'd35: g = {8'h22, 8'h41, 8'h41, 8'h41, 8'h3E};
      6'd36: g = {8'h1C, 8'h22, 8'h41, 8'h41, 8'h7F};
      6'd37: g = {8'h41, 8'h49, 8'h49, 8'h49, 8'h7F};
      6'd38: g = {8'h01, 8'h09, 8'h09, 8'h09, 8'h7F};
      6'd39: g = {8'h7A, 8'h49, 8'h49, 8'h41, 8'h3E};
      6'd40: g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
      6'd41: g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
      6'd42: g = {8'h01, 8'h3F, 8'h41, 8'h40, 8'h20};
      6'd43: g = {8'h41, 8'h22, 8'h14, 8'h08, 8'h7F};
      6'd44: g = {8'h40, 8'h40, 8'h40, 8'h40, 8'h7F};
      6'd45: g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
      6'd46: g = {8'h7F, 8'h10, 8'h0C, 8'h02, 8'h7F};
      6'd47: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
      6'd48: g = {8'h06, 8'h09, 8'h09, 8'h09, 8'h7F};
      6'd49: g = {8'h5E, 8'h21, 8'h51, 8'h41, 8'h3E};
      6'd50: g = {8'h46, 8'h29, 8'h19, 8'h09, 8'h7F};
      6'd51: g = {8'h31, 8'h49, 8'h49, 8'h49, 8'h46};
      6'd52: g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
      6'd53: g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
      6'd54: g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
      6'd55: g = {8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F};
      6'd56: g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
      6'd57: g = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
      6'd58: g = {8'h43, 8'h45, 8'h49, 8'h51, 8'h61};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

/* src/text_glyph_pixel_rasterizer.sv */
// Renders text one character per input transfer into panel pixels of a 5x8 font, one
// output transfer per on-screen pixel, glyph columns outer and rows inner, tlast on the
// final pixel of each character. A character yields one transfer per visible pixel, 40
// at most, from the pixel sequencer that steps the glyph one pixel per cycle unless the
// output is stalled; characters that draw nothing (end code, no active string, cursor off
// the right edge, glyph entirely below the screen) are consumed without entering the queue.
// A two-entry queue between the character decoder and the pixel sequencer lets the next
// characters be taken while pixels of the current one are still going out. Offsets are to
// be written through the cfg port only while the block is idle; the block does not enforce it.
module text_glyph_pixel_rasterizer
  import tgpr_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = 240,
  parameter int unsigned SCREEN_HEIGHT = 135
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // start_x[8:0], start_y[16:9], char_code[24:17], fg_color[40:25], clear_color[56:41]
  input  logic [63:0] in_tdata,
  // first[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // panel_column[9:0], panel_row[18:10], dot_color[34:19]
  output logic [39:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);

  logic [7:0]  column_offset_r;
  logic [7:0]  row_offset_r;

  logic        push_valid, push_ready;
  job_t        push_data;
  logic        pop_valid, pop_ready;
  job_t        pop_data;
  logic [9:0]  panel_column;
  logic [8:0]  panel_row;
  logic [15:0] dot_color;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_offset_r <= COLUMN_OFFSET_RESET;
      row_offset_r    <= ROW_OFFSET_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLUMN_OFFSET: column_offset_r <= cfg_wdata;
        REG_ROW_OFFSET:    row_offset_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tgpr_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .first      (in_tuser),
    .start_x    (in_tdata[8:0]),
    .start_y    (in_tdata[16:9]),
    .char_code  (in_tdata[24:17]),
    .fg_color   (in_tdata[40:25]),
    .clear_color(in_tdata[56:41]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  tgpr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  tgpr_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .column_offset(column_offset_r),
    .row_offset   (row_offset_r),
    .job_valid    (pop_valid),
    .job_ready    (pop_ready),
    .job_data     (pop_data),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .panel_column (panel_column),
    .panel_row    (panel_row),
    .dot_color    (dot_color),
    .last_pixel   (out_tlast)
  );

  assign out_tdata = {5'd0, dot_color, panel_row, panel_column};

endmodule

/* src/tgpr_front.sv */
module tgpr_front
  import tgpr_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = 240,
  parameter int unsigned SCREEN_HEIGHT = 135
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        first,
  input  logic [8:0]  start_x,
  input  logic [7:0]  start_y,
  input  logic [7:0]  char_code,
  input  logic [15:0] fg_color,
  input  logic [15:0] clear_color,
  output logic        push_valid,
  input  logic        push_ready,
  output job_t        push_data
);

  localparam logic [9:0] WIDTH_LIM  = 10'(SCREEN_WIDTH);
  localparam logic [8:0] HEIGHT_LIM = 9'(SCREEN_HEIGHT);

  logic [9:0] cursor_x_r, cursor_x_nxt;
  logic [7:0] line_y_r, line_y_nxt;
  logic       ended_r, ended_nxt;

  logic [9:0] x_eff;
  logic [7:0] y_eff;
  logic       ended_eff;
  logic       render_c;
  logic       rows_visible;
  logic [9:0] dx;
  logic [8:0] dy;
  logic [5:0] idx_c;

  always_comb begin
    x_eff     = first ? {1'b0, start_x} : cursor_x_r;
    y_eff     = first ? start_y : line_y_r;
    ended_eff = first ? 1'b0 : ended_r;

    render_c     = !ended_eff && (char_code != END_CODE) && (x_eff < WIDTH_LIM);
    rows_visible = {1'b0, y_eff} < HEIGHT_LIM;

    // Only meaningful when the character is drawn, so x and y are on screen.
    dx = WIDTH_LIM - 10'd1 - x_eff;
    dy = HEIGHT_LIM - 9'd1 - {1'b0, y_eff};

    if (char_code inside {[FIRST_CODE:LAST_CODE]}) begin
      idx_c = 6'(char_code - FIRST_CODE);
    end else begin
      idx_c = '0;
    end

    push_data.x        = x_eff[8:0];
    push_data.y        = y_eff;
    push_data.idx      = idx_c;
    push_data.last_col = (dx >= 10'(LAST_GLYPH_COL)) ? LAST_GLYPH_COL : dx[2:0];
    push_data.last_row = (dy >= 9'(LAST_GLYPH_ROW)) ? LAST_GLYPH_ROW : dy[2:0];
    push_data.fg       = fg_color;
    push_data.bg       = clear_color;

    // A character whose rows are all below the screen still moves the cursor.
    push_valid = in_valid && render_c && rows_visible;
    in_ready   = push_ready;

    cursor_x_nxt = cursor_x_r;
    line_y_nxt   = line_y_r;
    ended_nxt    = ended_r;
    if (in_valid && in_ready) begin
      cursor_x_nxt = x_eff;
      line_y_nxt   = y_eff;
      ended_nxt    = ended_eff;
      if (!ended_eff) begin
        if (render_c) begin
          cursor_x_nxt = x_eff + ADVANCE;
        end else begin
          ended_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r <= '0;
      line_y_r   <= '0;
      ended_r    <= 1'b1;
    end else begin
      cursor_x_r <= cursor_x_nxt;
      line_y_r   <= line_y_nxt;
      ended_r    <= ended_nxt;
    end
  end

endmodule

/* src/tgpr_queue.sv */
module tgpr_queue
  import tgpr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  job_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  always_comb begin
    push_ready = count_r != FULL_CNT;
    pop_valid  = count_r != '0;
    pop_data   = mem[rd_ptr_r];
    do_push    = push_valid && push_ready;
    do_pop     = pop_valid && pop_ready;

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* src/tgpr_back.sv */
module tgpr_back
  import tgpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  column_offset,
  input  logic [7:0]  row_offset,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  panel_column,
  output logic [8:0]  panel_row,
  output logic [15:0] dot_color,
  output logic        last_pixel
);

  logic        busy_r, busy_nxt;
  job_t        job_r;
  logic [2:0]  col_r, col_nxt;
  logic [2:0]  row_r, row_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [9:0]  column_r;
  logic [8:0]  row_addr_r;
  logic [15:0] color_r;
  logic        last_r;

  glyph_t      glyph_c;
  logic [7:0]  bits_c;
  logic        advance;
  logic        at_end;
  logic        load;
  logic [9:0]  sx;
  logic [8:0]  sy;

  always_comb begin
    glyph_c = font_cols(job_r.idx);
    bits_c  = glyph_c[col_r];
    sx      = 10'(job_r.x) + 10'(col_r);
    sy      = 9'(job_r.y) + 9'(row_r);

    advance = busy_r && (!out_valid_r || out_ready);
    at_end  = (col_r == job_r.last_col) && (row_r == job_r.last_row);
    // The next character is taken in the same cycle its predecessor's last pixel is
    // loaded into the output register.
    load      = !busy_r || (advance && at_end);
    job_ready = load;

    busy_nxt = busy_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (advance) begin
      if (row_r == job_r.last_row) begin
        row_nxt = '0;
        col_nxt = col_r + 3'd1;
      end else begin
        row_nxt = row_r + 3'd1;
      end
      if (at_end) begin
        busy_nxt = 1'b0;
      end
    end
    if (load && job_valid) begin
      busy_nxt = 1'b1;
      col_nxt  = '0;
      row_nxt  = '0;
    end

    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    out_valid    = out_valid_r;
    panel_column = column_r;
    panel_row    = row_addr_r;
    dot_color    = color_r;
    last_pixel   = last_r;
  end

  always_ff @(posedge clk) begin
    if (load && job_valid) begin
      job_r <= job_data;
    end
    if (advance) begin
      column_r   <= sx + 10'(column_offset);
      row_addr_r <= sy + 9'(row_offset);
      color_r    <= bits_c[row_r] ? job_r.fg : job_r.bg;
      last_r     <= at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* src/tgpr_checker.sv */
module tgpr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);

  // A result held back by the sink stays offered.
  a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped without a transfer");

  a_out_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("output payload changed while stalled");

  // Within a character the pixel sequencer never leaves a gap.
  a_no_gap_in_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap in the pixel run of a character");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("outputs not idle after reset");

endmodule

bind text_glyph_pixel_rasterizer tgpr_checker u_tgpr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);
